>>> design/scd_pkg.sv
// shared types and constants of the servo current stall detector
package scd_pkg;

    localparam int ADC_BITS   = 10;
    localparam int CMD_W      = 8;
    localparam int TOL_W      = 11;
    localparam int OP_W       = 2;
    localparam int MARGIN_W   = 14;
    localparam int SIDE_W     = 2;
    localparam int LIMIT_W    = 11;
    localparam int SUM3_W     = ADC_BITS + 2;
    localparam int PROD_W     = 2 * ADC_BITS + 1;
    localparam int MFULL_W    = PROD_W + 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam int AVG_COUNT   = 3;
    localparam int STARTUP_MIN = 1;
    localparam int MARGIN_MAX  = 8191;
    localparam int MARGIN_MIN  = -8192;

    localparam logic [OP_W-1:0] OP_BEGIN = 2'd0;
    localparam logic [OP_W-1:0] OP_POLL  = 2'd1;
    localparam logic [OP_W-1:0] OP_STEP  = 2'd2;

    localparam logic [SIDE_W-1:0] SIDE_NONE   = 2'd0;
    localparam logic [SIDE_W-1:0] SIDE_OPEN   = 2'd1;
    localparam logic [SIDE_W-1:0] SIDE_CLOSED = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STARTUP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STALL_LVL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL_LOW   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL_HIGH  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 3'd7;

    localparam logic [CMD_W-1:0]    CENTER_RESET    = 8'd90;
    localparam logic [ADC_BITS-1:0] STALL_LVL_RESET = 10'd1023;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET     = 11'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV3_GO,
        ST_DIV3,
        ST_MUL,
        ST_TDIV_GO,
        ST_TDIV,
        ST_MDIV_GO,
        ST_MDIV,
        ST_DONE
    } t_state;

endpackage

>>> design/scd_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module scd_div #(
    parameter int DW = 21,
    parameter int VW = 11
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [DW-1:0]            i_dividend,
    input  logic [VW-1:0]            i_divisor,
    input  logic [$clog2(DW+1)-1:0]  i_iters,
    output logic                     o_done,
    output logic [DW-1:0]            o_quotient
);

    localparam int CNTW = $clog2(DW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [VW-1:0]   r_rem;
    logic [VW-1:0]   r_den;
    logic [DW-1:0]   r_quo;
    logic [VW:0]     w_shift;
    logic [VW:0]     w_diff;
    logic            w_ge;

    assign w_shift = {r_rem, r_quo[DW-1]};
    assign w_diff  = w_shift - {1'b0, r_den};
    assign w_ge    = (w_shift >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_iters;
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[VW-1:0] : w_shift[VW-1:0];
            r_quo <= {r_quo[DW-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> design/servo_current_stall_detector_top.sv
// servo current stall detector: move state, tolerance map and result register
//
// input channel: one beat per operation (begin, poll, step) with three current
// readings and the drive command; accepted when i_in_valid is high and
// o_in_stall is low. output channel: one result beat per input beat, taken
// when o_out_valid is high and i_out_stall is low. configuration writes go
// through i_cfg_valid / o_cfg_ready, which is always high.
// begin, poll and ignored steps go from accept straight to the done state and
// then into the output register. a step takes the average through the
// bit-serial divider (ADC_BITS+2 bits), then, when a previous level exists and
// the map span is nonzero, a shift-add multiply and a divide by the span
// (2*ADC_BITS+1 bits); the running mean is a divide of
// ADC_BITS+clog2(MAX_STEPS+1) bits.
// one operation is in flight at a time; the next beat is accepted as soon as
// the result is in the output register, even while the receiver stalls.
// a stalled result holds until taken, and a finished operation waits for the
// output register to free. reset clears the move state, loads the register
// reset values and empties the output register.
module servo_current_stall_detector_top #(
    parameter int MAX_STEPS = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [scd_pkg::OP_W-1:0]              i_operation,
    input  logic [scd_pkg::ADC_BITS-1:0]          i_reading_a,
    input  logic [scd_pkg::ADC_BITS-1:0]          i_reading_b,
    input  logic [scd_pkg::ADC_BITS-1:0]          i_reading_c,
    input  logic [scd_pkg::CMD_W-1:0]             i_drive_command,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic                                  o_started,
    output logic [scd_pkg::ADC_BITS-1:0]          o_sample_level,
    output logic [scd_pkg::ADC_BITS-1:0]          o_mean_load,
    output logic [scd_pkg::ADC_BITS-1:0]          o_peak_level,
    output logic signed [scd_pkg::MARGIN_W-1:0]   o_margin,
    output logic                                  o_stalled,
    output logic [scd_pkg::SIDE_W-1:0]            o_stall_side,
    output logic                                  o_move_done,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [scd_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [scd_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int LW   = scd_pkg::ADC_BITS;
    localparam int CW   = scd_pkg::CMD_W;
    localparam int TW   = scd_pkg::TOL_W;
    localparam int OPW  = scd_pkg::OP_W;
    localparam int MGW  = scd_pkg::MARGIN_W;
    localparam int SDW  = scd_pkg::SIDE_W;
    localparam int LMW  = scd_pkg::LIMIT_W;
    localparam int S3W  = scd_pkg::SUM3_W;
    localparam int PW   = scd_pkg::PROD_W;
    localparam int MFW  = scd_pkg::MFULL_W;
    localparam int SW   = $clog2(MAX_STEPS + 1);
    localparam int SUMW = LW + SW;
    localparam int DW   = (PW > SUMW) ? PW : SUMW;
    localparam int VW   = (LW > SW) ? LW : SW;
    localparam int CNTW = $clog2(DW + 1);
    localparam int CMPW = (SW > LMW) ? SW : LMW;
    localparam int MCW  = $clog2(LW + 1);
    localparam logic [CMPW-1:0] MAX_LIMIT = CMPW'(MAX_STEPS);

    scd_pkg::t_state r_state;
    scd_pkg::t_state n_state;

    // configuration
    logic [CW-1:0]        r_center;
    logic                 r_stop;
    logic [LW-1:0]        r_thr;
    logic [LW-1:0]        r_nominal;
    logic [LW-1:0]        r_stall_lvl;
    logic signed [TW-1:0] r_tol_low;
    logic signed [TW-1:0] r_tol_high;
    logic [LMW-1:0]       r_limit;

    // move state
    logic [LW-1:0]   r_prev;
    logic [SUMW-1:0] r_sum;
    logic [SW-1:0]   r_steps;
    logic [LW-1:0]   r_peak;
    logic            r_stall;
    logic [SDW-1:0]  r_side;
    logic            r_start;
    logic [LW-1:0]   r_mean;

    logic [LW-1:0]   n_prev;
    logic [SUMW-1:0] n_sum;
    logic [SW-1:0]   n_steps;
    logic [LW-1:0]   n_peak;
    logic            n_stall;
    logic [SDW-1:0]  n_side;
    logic            n_start;
    logic [LW-1:0]   n_mean;
    logic [LW-1:0]   n_res_sample;
    logic signed [MGW-1:0] n_res_margin;
    logic            n_res_done;

    // operation in flight
    logic [OPW-1:0]        r_op;
    logic [S3W-1:0]        r_sum3;
    logic [LW-1:0]         r_ra;
    logic [CW-1:0]         r_drive;
    logic [LW-1:0]         r_sample;
    logic signed [MFW-1:0] r_tol;
    logic                  r_neg;
    logic [PW-1:0]         r_mcand;
    logic [LW-1:0]         r_mplier;
    logic [PW-1:0]         r_prod;
    logic [MCW-1:0]        r_mcnt;
    logic [LW-1:0]         r_qmean;

    // result register
    logic                  r_out_valid;
    logic                  r_out_started;
    logic [LW-1:0]         r_out_sample;
    logic [LW-1:0]         r_out_mean;
    logic [LW-1:0]         r_out_peak;
    logic signed [MGW-1:0] r_out_margin;
    logic                  r_out_stalled;
    logic [SDW-1:0]        r_out_side;
    logic                  r_out_done;

    logic                  div_start;
    logic [DW-1:0]         div_dividend;
    logic [VW-1:0]         div_divisor;
    logic [CNTW-1:0]       div_iters;
    logic                  div_done;
    logic [DW-1:0]         div_quo;

    logic [CMPW-1:0]       w_limit;
    logic                  w_ended;
    logic                  w_can_step;
    logic                  w_accept;
    logic                  w_out_free;
    logic                  w_commit;
    logic [LW-1:0]         w_quo_lvl;
    logic signed [LW:0]    w_sn;
    logic signed [TW:0]    w_dt;
    logic signed [LW:0]    w_span;
    logic [LW-1:0]         w_sn_mag;
    logic [TW-1:0]         w_dt_mag;
    logic [LW-1:0]         w_span_mag;
    logic [SUMW-1:0]       w_sum_next;
    logic [SW-1:0]         w_steps_next;
    logic signed [MFW-1:0] w_tq;
    logic signed [LW:0]    w_drop;
    logic                  w_measure;
    logic signed [MFW-1:0] w_margin_full;
    logic                  w_trip;

    assign w_limit    = (CMPW'(r_limit) < MAX_LIMIT) ? CMPW'(r_limit) : MAX_LIMIT;
    assign w_ended    = r_stall || (CMPW'(r_steps) >= w_limit);
    assign w_can_step = r_start && !w_ended;
    assign w_accept   = i_in_valid && (r_state == scd_pkg::ST_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_commit   = (r_state == scd_pkg::ST_DONE) && w_out_free;

    assign w_quo_lvl  = div_quo[LW-1:0];
    assign w_sn       = $signed({1'b0, w_quo_lvl}) - $signed({1'b0, r_nominal});
    assign w_dt       = $signed({r_tol_high[TW-1], r_tol_high})
                      - $signed({r_tol_low[TW-1], r_tol_low});
    assign w_span     = $signed({1'b0, r_stall_lvl}) - $signed({1'b0, r_nominal});
    assign w_sn_mag   = w_sn[LW] ? LW'(-w_sn) : LW'(w_sn);
    assign w_dt_mag   = w_dt[TW] ? TW'(-w_dt) : TW'(w_dt);
    assign w_span_mag = w_span[LW] ? LW'(-w_span) : LW'(w_span);

    assign w_sum_next   = r_sum + SUMW'(r_sample);
    assign w_steps_next = r_steps + SW'(1);
    assign w_tq         = $signed(MFW'(div_quo[PW-1:0]));

    assign w_measure     = (r_prev != '0);
    assign w_drop        = $signed({1'b0, r_prev}) - $signed({1'b0, r_sample});
    assign w_margin_full = w_measure ? (MFW'(w_drop) + r_tol) : '0;
    assign w_trip        = r_stop && w_measure && w_margin_full[MFW-1];

    scd_div #(
        .DW (DW),
        .VW (VW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .i_iters    (div_iters),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            scd_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_operation == scd_pkg::OP_STEP && w_can_step) begin
                        n_state = scd_pkg::ST_DIV3_GO;
                    end else begin
                        n_state = scd_pkg::ST_DONE;
                    end
                end
            end
            scd_pkg::ST_DIV3_GO: begin
                n_state = scd_pkg::ST_DIV3;
            end
            scd_pkg::ST_DIV3: begin
                if (div_done) begin
                    if (!w_measure || w_span == '0) begin
                        n_state = scd_pkg::ST_MDIV_GO;
                    end else begin
                        n_state = scd_pkg::ST_MUL;
                    end
                end
            end
            scd_pkg::ST_MUL: begin
                if (r_mcnt == MCW'(1)) begin
                    n_state = scd_pkg::ST_TDIV_GO;
                end
            end
            scd_pkg::ST_TDIV_GO: begin
                n_state = scd_pkg::ST_TDIV;
            end
            scd_pkg::ST_TDIV: begin
                if (div_done) begin
                    n_state = scd_pkg::ST_MDIV_GO;
                end
            end
            scd_pkg::ST_MDIV_GO: begin
                n_state = scd_pkg::ST_MDIV;
            end
            scd_pkg::ST_MDIV: begin
                if (div_done) begin
                    n_state = scd_pkg::ST_DONE;
                end
            end
            scd_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = scd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = scd_pkg::ST_IDLE;
            end
        endcase
    end

    // divider requests
    always_comb begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        div_iters    = '0;
        case (r_state)
            scd_pkg::ST_DIV3_GO: begin
                div_start    = 1'b1;
                div_dividend = DW'(r_sum3) << (DW - S3W);
                div_divisor  = VW'(scd_pkg::AVG_COUNT);
                div_iters    = CNTW'(S3W);
            end
            scd_pkg::ST_TDIV_GO: begin
                div_start    = 1'b1;
                div_dividend = DW'(r_prod) << (DW - PW);
                div_divisor  = VW'(w_span_mag);
                div_iters    = CNTW'(PW);
            end
            scd_pkg::ST_MDIV_GO: begin
                div_start    = 1'b1;
                div_dividend = DW'(w_sum_next) << (DW - SUMW);
                div_divisor  = VW'(w_steps_next);
                div_iters    = CNTW'(SUMW);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    // state after the operation and its result
    always_comb begin
        n_prev       = r_prev;
        n_sum        = r_sum;
        n_steps      = r_steps;
        n_peak       = r_peak;
        n_stall      = r_stall;
        n_side       = r_side;
        n_start      = r_start;
        n_mean       = r_mean;
        n_res_sample = '0;
        n_res_margin = '0;
        n_res_done   = 1'b0;
        case (r_op)
            scd_pkg::OP_BEGIN: begin
                n_prev  = '0;
                n_sum   = '0;
                n_steps = '0;
                n_peak  = '0;
                n_stall = 1'b0;
                n_side  = scd_pkg::SIDE_NONE;
                n_start = 1'b0;
                n_mean  = '0;
            end
            scd_pkg::OP_POLL: begin
                if (!r_start && (r_thr <= LW'(scd_pkg::STARTUP_MIN) || r_ra >= r_thr)) begin
                    n_start = 1'b1;
                    n_prev  = '0;
                end
            end
            scd_pkg::OP_STEP: begin
                if (r_start) begin
                    if (w_ended) begin
                        n_res_done = 1'b1;
                    end else begin
                        n_res_sample = r_sample;
                        n_prev       = r_sample;
                        n_sum        = w_sum_next;
                        n_steps      = w_steps_next;
                        n_mean       = r_qmean;
                        if (w_measure) begin
                            if (w_margin_full > MFW'(scd_pkg::MARGIN_MAX)) begin
                                n_res_margin = MGW'(scd_pkg::MARGIN_MAX);
                            end else if (w_margin_full < MFW'(scd_pkg::MARGIN_MIN)) begin
                                n_res_margin = MGW'(scd_pkg::MARGIN_MIN);
                            end else begin
                                n_res_margin = w_margin_full[MGW-1:0];
                            end
                            if (r_sample > r_peak) begin
                                n_peak = r_sample;
                            end
                        end
                        if (w_trip) begin
                            n_stall = 1'b1;
                            if (r_drive < r_center) begin
                                n_side = scd_pkg::SIDE_OPEN;
                            end else if (r_drive > r_center) begin
                                n_side = scd_pkg::SIDE_CLOSED;
                            end
                        end
                        n_res_done = n_stall || (CMPW'(w_steps_next) >= w_limit);
                    end
                end
            end
            default: begin
                n_res_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= scd_pkg::ST_IDLE;
            r_center    <= scd_pkg::CENTER_RESET;
            r_stop      <= 1'b1;
            r_thr       <= '0;
            r_nominal   <= '0;
            r_stall_lvl <= scd_pkg::STALL_LVL_RESET;
            r_tol_low   <= '0;
            r_tol_high  <= '0;
            r_limit     <= scd_pkg::LIMIT_RESET;
            r_prev      <= '0;
            r_sum       <= '0;
            r_steps     <= '0;
            r_peak      <= '0;
            r_stall     <= 1'b0;
            r_side      <= scd_pkg::SIDE_NONE;
            r_start     <= 1'b0;
            r_mean      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    scd_pkg::CFG_CENTER:    r_center    <= i_cfg_data[CW-1:0];
                    scd_pkg::CFG_STOP:      r_stop      <= i_cfg_data[0];
                    scd_pkg::CFG_STARTUP:   r_thr       <= i_cfg_data[LW-1:0];
                    scd_pkg::CFG_NOMINAL:   r_nominal   <= i_cfg_data[LW-1:0];
                    scd_pkg::CFG_STALL_LVL: r_stall_lvl <= i_cfg_data[LW-1:0];
                    scd_pkg::CFG_TOL_LOW:   r_tol_low   <= $signed(i_cfg_data[TW-1:0]);
                    scd_pkg::CFG_TOL_HIGH:  r_tol_high  <= $signed(i_cfg_data[TW-1:0]);
                    scd_pkg::CFG_LIMIT:     r_limit     <= i_cfg_data[LMW-1:0];
                    default: begin
                        r_limit <= r_limit;
                    end
                endcase
            end
            if (w_commit) begin
                r_prev      <= n_prev;
                r_sum       <= n_sum;
                r_steps     <= n_steps;
                r_peak      <= n_peak;
                r_stall     <= n_stall;
                r_side      <= n_side;
                r_start     <= n_start;
                r_mean      <= n_mean;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= i_operation;
            r_sum3  <= S3W'(i_reading_a) + S3W'(i_reading_b) + S3W'(i_reading_c);
            r_ra    <= i_reading_a;
            r_drive <= i_drive_command;
        end
        if (r_state == scd_pkg::ST_DIV3 && div_done) begin
            r_sample <= w_quo_lvl;
            r_tol    <= MFW'(r_tol_low);
            r_neg    <= w_sn[LW] ^ w_dt[TW] ^ w_span[LW];
            r_mcand  <= PW'(w_dt_mag);
            r_mplier <= w_sn_mag;
            r_prod   <= '0;
            r_mcnt   <= MCW'(LW);
        end
        if (r_state == scd_pkg::ST_MUL) begin
            if (r_mplier[0]) begin
                r_prod <= r_prod + r_mcand;
            end
            r_mcand  <= {r_mcand[PW-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[LW-1:1]};
            r_mcnt   <= r_mcnt - MCW'(1);
        end
        if (r_state == scd_pkg::ST_TDIV && div_done) begin
            r_tol <= (r_neg ? -w_tq : w_tq) + MFW'(r_tol_low);
        end
        if (r_state == scd_pkg::ST_MDIV && div_done) begin
            r_qmean <= div_quo[LW-1:0];
        end
        if (w_commit) begin
            r_out_started <= n_start;
            r_out_sample  <= n_res_sample;
            r_out_mean    <= n_mean;
            r_out_peak    <= n_peak;
            r_out_margin  <= n_res_margin;
            r_out_stalled <= n_stall;
            r_out_side    <= n_side;
            r_out_done    <= n_res_done;
        end
    end

    assign o_in_stall     = (r_state != scd_pkg::ST_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_valid;
    assign o_started      = r_out_started;
    assign o_sample_level = r_out_sample;
    assign o_mean_load    = r_out_mean;
    assign o_peak_level   = r_out_peak;
    assign o_margin       = r_out_margin;
    assign o_stalled      = r_out_stalled;
    assign o_stall_side   = r_out_side;
    assign o_move_done    = r_out_done;

endmodule

>>> design/scd_check.sv
// port-level checks of the stall detector and their bind to the top level
module scd_check (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    input  logic                                  o_in_stall,
    input  logic [scd_pkg::OP_W-1:0]              i_operation,
    input  logic [scd_pkg::ADC_BITS-1:0]          i_reading_a,
    input  logic [scd_pkg::ADC_BITS-1:0]          i_reading_b,
    input  logic [scd_pkg::ADC_BITS-1:0]          i_reading_c,
    input  logic [scd_pkg::CMD_W-1:0]             i_drive_command,
    input  logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    input  logic                                  o_started,
    input  logic [scd_pkg::ADC_BITS-1:0]          o_sample_level,
    input  logic [scd_pkg::ADC_BITS-1:0]          o_mean_load,
    input  logic [scd_pkg::ADC_BITS-1:0]          o_peak_level,
    input  logic signed [scd_pkg::MARGIN_W-1:0]   o_margin,
    input  logic                                  o_stalled,
    input  logic [scd_pkg::SIDE_W-1:0]            o_stall_side,
    input  logic                                  o_move_done,
    input  logic                                  i_cfg_valid,
    input  logic                                  o_cfg_ready,
    input  logic [scd_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [scd_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_margin) && $stable(o_mean_load)
            && $stable(o_stall_side) && $stable(o_move_done))
        else $error("result beat changed while stalled");

    // a stall side only comes with a stall
    a_side_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_stall_side != scd_pkg::SIDE_NONE) |-> o_stalled)
        else $error("stall side without stall");

    // before startup the move has no measurements
    a_not_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_started |->
            !o_stalled && !o_move_done && (o_mean_load == '0)
            && (o_peak_level == '0) && (o_sample_level == '0) && (o_margin == '0))
        else $error("measurement shown before startup");

    // output register empty right after reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result beat right after reset");

endmodule

bind servo_current_stall_detector_top scd_check u_scd_check (.*);

>>> bench/testbench.sv
// self-checking testbench for the servo current stall detector: queued beats, predicted status
`timescale 1ns / 1ps

module testbench;
    import scd_pkg::*;

    localparam int MAX_STEPS     = 1024;
    localparam int LEVEL_MAX     = (1 << ADC_BITS) - 1;
    localparam int CMD_MAX       = 180;
    localparam int ITEM_GOAL     = 1450;
    localparam int SETTLE_CYCLES = 100;
    localparam int LONG_HOLD     = 400;
    localparam int STUCK_LIMIT   = 4000;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [ADC_BITS-1:0] a;
        logic [ADC_BITS-1:0] b;
        logic [ADC_BITS-1:0] c;
        logic [CMD_W-1:0]    drive;
    } sense_beat_t;

    typedef struct packed {
        logic                       started;
        logic [ADC_BITS-1:0]        level;
        logic [ADC_BITS-1:0]        mean;
        logic [ADC_BITS-1:0]        peak;
        logic signed [MARGIN_W-1:0] margin;
        logic                       stalled;
        logic [SIDE_W-1:0]          side;
        logic                       done;
    } status_t;

    logic                       i_clk;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic [OP_W-1:0]            i_operation = '0;
    logic [ADC_BITS-1:0]        i_reading_a = '0;
    logic [ADC_BITS-1:0]        i_reading_b = '0;
    logic [ADC_BITS-1:0]        i_reading_c = '0;
    logic [CMD_W-1:0]           i_drive_command = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic                       o_started;
    logic [ADC_BITS-1:0]        o_sample_level;
    logic [ADC_BITS-1:0]        o_mean_load;
    logic [ADC_BITS-1:0]        o_peak_level;
    logic signed [MARGIN_W-1:0] o_margin;
    logic                       o_stalled;
    logic [SIDE_W-1:0]          o_stall_side;
    logic                       o_move_done;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data = '0;

    // register copies
    logic [CMD_W-1:0]        cfg_center    = CENTER_RESET;
    logic                    cfg_stop      = 1'b1;
    logic [ADC_BITS-1:0]     cfg_startup   = '0;
    logic [ADC_BITS-1:0]     cfg_nominal   = '0;
    logic [ADC_BITS-1:0]     cfg_stall_lvl = STALL_LVL_RESET;
    logic signed [TOL_W-1:0] cfg_tol_low   = '0;
    logic signed [TOL_W-1:0] cfg_tol_high  = '0;
    logic [LIMIT_W-1:0]      cfg_limit     = LIMIT_RESET;

    // move state
    logic [ADC_BITS-1:0] move_prev    = '0;
    int unsigned         move_sum     = 0;
    int unsigned         move_steps   = 0;
    logic [ADC_BITS-1:0] move_peak    = '0;
    logic                move_stalled = 1'b0;
    logic [SIDE_W-1:0]   move_side    = SIDE_NONE;
    logic                move_started = 1'b0;

    sense_beat_t sense_beats[$];
    status_t     expected_status[$];
    int          beats_queued = 0;
    int          beats_taken  = 0;
    int          mismatches   = 0;
    int          stuck_cycles = 0;
    int          idle_odds    = 0;
    int          send_gap     = 0;
    int          stall_left   = 0;
    int          hold_left    = 0;
    logic        hold_request = 1'b0;
    logic        beat_taken   = 1'b0;

    servo_current_stall_detector_top #(
        .MAX_STEPS(MAX_STEPS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_reading_a    (i_reading_a),
        .i_reading_b    (i_reading_b),
        .i_reading_c    (i_reading_c),
        .i_drive_command(i_drive_command),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_started      (o_started),
        .o_sample_level (o_sample_level),
        .o_mean_load    (o_mean_load),
        .o_peak_level   (o_peak_level),
        .o_margin       (o_margin),
        .o_stalled      (o_stalled),
        .o_stall_side   (o_stall_side),
        .o_move_done    (o_move_done),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic status_t predict_status(sense_beat_t beat);
        status_t     s;
        int unsigned lim;
        int unsigned avg;
        int unsigned mean;
        longint      drop;
        longint      span;
        longint      tol;
        longint      mg;
        s   = '0;
        avg = 0;
        mg  = 0;
        lim = (cfg_limit < MAX_STEPS) ? cfg_limit : MAX_STEPS;
        case (beat.op)
            OP_BEGIN: begin
                move_prev    = '0;
                move_sum     = 0;
                move_steps   = 0;
                move_peak    = '0;
                move_stalled = 1'b0;
                move_side    = SIDE_NONE;
                move_started = 1'b0;
            end
            OP_POLL: begin
                if (!move_started && (cfg_startup <= STARTUP_MIN || beat.a >= cfg_startup)) begin
                    move_started = 1'b1;
                    move_prev    = '0;
                end
            end
            OP_STEP: begin
                if (move_started) begin
                    if (move_stalled || move_steps >= lim) begin
                        s.done = 1'b1;
                    end else begin
                        avg = (int'(beat.a) + int'(beat.b) + int'(beat.c)) / AVG_COUNT;
                        if (move_prev == 0) begin
                            move_prev = avg[ADC_BITS-1:0];
                        end else begin
                            drop = longint'(move_prev) - longint'(avg);
                            span = longint'(cfg_stall_lvl) - longint'(cfg_nominal);
                            if (span == 0) begin
                                tol = longint'(cfg_tol_low);
                            end else begin
                                tol = (longint'(avg) - longint'(cfg_nominal))
                                    * (longint'(cfg_tol_high) - longint'(cfg_tol_low)) / span
                                    + longint'(cfg_tol_low);
                            end
                            mg = drop + tol;
                            if (avg > move_peak) move_peak = avg[ADC_BITS-1:0];
                            move_prev = avg[ADC_BITS-1:0];
                            if (cfg_stop && mg < 0) begin
                                move_stalled = 1'b1;
                                if (beat.drive < cfg_center) move_side = SIDE_OPEN;
                                else if (beat.drive > cfg_center) move_side = SIDE_CLOSED;
                            end
                            if (mg > MARGIN_MAX) mg = MARGIN_MAX;
                            if (mg < MARGIN_MIN) mg = MARGIN_MIN;
                        end
                        move_sum += move_prev;
                        move_steps++;
                        if (move_stalled || move_steps >= lim) s.done = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        mean      = (move_steps != 0) ? move_sum / move_steps : 0;
        s.started = move_started;
        s.level   = avg[ADC_BITS-1:0];
        s.mean    = mean[ADC_BITS-1:0];
        s.peak    = move_peak;
        s.margin  = mg[MARGIN_W-1:0];
        s.stalled = move_stalled;
        s.side    = move_side;
        return s;
    endfunction

    function automatic void check_field(string field, logic signed [31:0] want,
                                        logic signed [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endfunction

    // input beats, held while stalled
    always @(negedge i_clk) begin
        sense_beat_t beat;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || beat_taken) begin
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (sense_beats.size() != 0 && idle_odds != 0
                         && $urandom_range(1, idle_odds) == 1) begin
                send_gap = $urandom_range(0, 17);
                i_in_valid <= 1'b0;
            end else if (sense_beats.size() != 0) begin
                beat = sense_beats.pop_front();
                i_operation     <= beat.op;
                i_reading_a     <= beat.a;
                i_reading_b     <= beat.b;
                i_reading_c     <= beat.c;
                i_drive_command <= beat.drive;
                i_in_valid      <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result side stalls
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_left    = LONG_HOLD;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            stall_left = $urandom_range(0, 17);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        status_t want;
        logic    progress;
        if (!i_rst_n) begin
            beat_taken = 1'b0;
        end else begin
            beat_taken = i_in_valid && !o_in_stall;
            progress   = beat_taken || (i_cfg_valid && o_cfg_ready);
            if (beat_taken) begin
                beats_taken++;
                expected_status.push_back(predict_status('{i_operation, i_reading_a,
                    i_reading_b, i_reading_c, i_drive_command}));
            end
            if (o_out_valid && !i_out_stall) begin
                progress = 1'b1;
                if (expected_status.size() == 0) begin
                    $error("result beat with no operation pending");
                    mismatches++;
                end else begin
                    want = expected_status.pop_front();
                    check_field("started", want.started, o_started);
                    check_field("sample_level", want.level, o_sample_level);
                    check_field("mean_load", want.mean, o_mean_load);
                    check_field("peak_level", want.peak, o_peak_level);
                    check_field("margin", want.margin, o_margin);
                    check_field("stalled", want.stalled, o_stalled);
                    check_field("stall_side", want.side, o_stall_side);
                    check_field("move_done", want.done, o_move_done);
                end
            end
            stuck_cycles = progress ? 0 : stuck_cycles + 1;
        end
    end

    initial begin
        while (stuck_cycles < STUCK_LIMIT) @(posedge i_clk);
        $display("FAILURE");
        $finish;
    end

    function automatic int clamp_level(int v);
        if (v < 0) return 0;
        if (v > LEVEL_MAX) return LEVEL_MAX;
        return v;
    endfunction

    function automatic int jitter(int level);
        return clamp_level(level + int'($urandom_range(0, 8)) - 4);
    endfunction

    function automatic int any_reading();
        return $urandom_range(0, LEVEL_MAX);
    endfunction

    function automatic int spread(int lo, int hi);
        case ($urandom_range(0, 7))
            0: return lo;
            1: return hi;
            default: return lo + int'($urandom_range(0, hi - lo));
        endcase
    endfunction

    function automatic void push_beat(logic [OP_W-1:0] op, int ra, int rb, int rc, int drive);
        sense_beat_t beat;
        beat.op    = op;
        beat.a     = ra[ADC_BITS-1:0];
        beat.b     = rb[ADC_BITS-1:0];
        beat.c     = rc[ADC_BITS-1:0];
        beat.drive = drive[CMD_W-1:0];
        sense_beats.push_back(beat);
        beats_queued++;
    endfunction

    function automatic void push_noise();
        push_beat($urandom_range(OP_BEGIN, OP_STEP), any_reading(), any_reading(),
                  any_reading(), $urandom_range(0, CMD_MAX));
    endfunction

    // begin, polls up to startup, then steps following a drifting load
    function automatic void run_move(int n_steps, logic qualify);
        int level;
        int drive;
        drive = ($urandom_range(0, 5) == 0) ? int'(cfg_center) : int'($urandom_range(0, CMD_MAX));
        level = any_reading();
        push_beat(OP_BEGIN, any_reading(), any_reading(), any_reading(), drive);
        if (cfg_startup > STARTUP_MIN) begin
            repeat ($urandom_range(0, 2))
                push_beat(OP_POLL, $urandom_range(0, cfg_startup - 1), any_reading(),
                          any_reading(), drive);
        end
        if (qualify)
            push_beat(OP_POLL, $urandom_range(cfg_startup, LEVEL_MAX), any_reading(),
                      any_reading(), drive);
        repeat (n_steps) begin
            case ($urandom_range(0, 11))
                0: level = level + int'($urandom_range(30, 400));
                1: level = level - int'($urandom_range(30, 400));
                2: level = 0;
                default: level = level + int'($urandom_range(0, 30)) - 15;
            endcase
            level = clamp_level(level);
            push_beat(OP_STEP, jitter(level), jitter(level), jitter(level), drive);
        end
    endfunction

    task automatic wait_idle();
        while (beats_taken != beats_queued || expected_status.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_CENTER:    cfg_center    = value[CMD_W-1:0];
            CFG_STOP:      cfg_stop      = value[0];
            CFG_STARTUP:   cfg_startup   = value[ADC_BITS-1:0];
            CFG_NOMINAL:   cfg_nominal   = value[ADC_BITS-1:0];
            CFG_STALL_LVL: cfg_stall_lvl = value[ADC_BITS-1:0];
            CFG_TOL_LOW:   cfg_tol_low   = value[TOL_W-1:0];
            CFG_TOL_HIGH:  cfg_tol_high  = value[TOL_W-1:0];
            CFG_LIMIT:     cfg_limit     = value[LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic random_setup();
        int nom;
        int top;
        int lo;
        int hi;
        write_reg(CFG_CENTER, spread(0, CMD_MAX));
        write_reg(CFG_STOP, $urandom_range(0, 4) != 0);
        case ($urandom_range(0, 4))
            0: write_reg(CFG_STARTUP, $urandom_range(0, STARTUP_MIN));
            1: write_reg(CFG_STARTUP, LEVEL_MAX);
            default: write_reg(CFG_STARTUP, $urandom_range(STARTUP_MIN + 1, 700));
        endcase
        case ($urandom_range(0, 5))
            0: begin
                nom = spread(0, LEVEL_MAX);
                top = nom;
            end
            1: begin
                nom = spread(512, LEVEL_MAX);
                top = $urandom_range(0, nom - 1);
            end
            2: begin
                nom = $urandom_range(0, 1000);
                top = nom + int'($urandom_range(1, 5));
            end
            default: begin
                nom = spread(0, 400);
                top = spread(nom + 1, LEVEL_MAX);
            end
        endcase
        write_reg(CFG_NOMINAL, nom);
        write_reg(CFG_STALL_LVL, top);
        if ($urandom_range(0, 3) == 0) begin
            lo = spread(-LEVEL_MAX, LEVEL_MAX);
            hi = spread(-LEVEL_MAX, LEVEL_MAX);
        end else begin
            lo = int'($urandom_range(0, 60)) - 10;
            hi = lo + int'($urandom_range(0, 200));
        end
        write_reg(CFG_TOL_LOW, lo);
        write_reg(CFG_TOL_HIGH, hi);
        case ($urandom_range(0, 5))
            0: write_reg(CFG_LIMIT, MAX_STEPS);
            1: write_reg(CFG_LIMIT, 1);
            default: write_reg(CFG_LIMIT, $urandom_range(2, 30));
        endcase
    endtask

    task automatic random_phase(int n_items);
        int goal;
        int cap;
        goal = beats_queued + n_items;
        random_setup();
        cap = (cfg_limit > 30) ? 40 : int'(cfg_limit) + 3;
        while (beats_queued < goal) begin
            if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(1, 4)) push_noise();
            end else begin
                run_move($urandom_range(1, cap), $urandom_range(0, 9) != 0);
            end
            if ($urandom_range(0, 7) == 0) wait_idle();
        end
        wait_idle();
    endtask

    initial begin
        int phase;
        int goal;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // register reset values: threshold zero, limit one
        push_beat(OP_STEP, 500, 500, 500, 0);
        push_beat(OP_UNUSED, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, CMD_MAX);
        push_beat(OP_POLL, 0, 0, 0, 90);
        push_beat(OP_STEP, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, CMD_MAX);
        push_beat(OP_STEP, 1, 2, 3, CMD_MAX);
        wait_idle();

        // zero tolerance: stalls on the open and the closed side
        write_reg(CFG_STARTUP, STARTUP_MIN);
        write_reg(CFG_LIMIT, MAX_STEPS);
        push_beat(OP_BEGIN, 0, 0, 0, 0);
        push_beat(OP_POLL, 0, 0, 0, 0);
        push_beat(OP_STEP, 10, 10, 10, 0);
        push_beat(OP_STEP, 20, 20, 20, 0);
        push_beat(OP_STEP, 5, 5, 5, 0);
        push_beat(OP_BEGIN, 0, 0, 0, CMD_MAX);
        push_beat(OP_POLL, 1, 0, 0, CMD_MAX);
        push_beat(OP_STEP, 10, 10, 10, CMD_MAX);
        push_beat(OP_STEP, 40, 40, 40, CMD_MAX);
        wait_idle();

        // limit of zero, then a span of one that saturates both ways
        write_reg(CFG_CENTER, CMD_MAX);
        write_reg(CFG_STOP, 0);
        write_reg(CFG_STARTUP, LEVEL_MAX);
        write_reg(CFG_NOMINAL, 500);
        write_reg(CFG_STALL_LVL, 501);
        write_reg(CFG_TOL_LOW, -LEVEL_MAX);
        write_reg(CFG_TOL_HIGH, LEVEL_MAX);
        write_reg(CFG_LIMIT, 0);
        push_beat(OP_BEGIN, 0, 0, 0, CMD_MAX);
        push_beat(OP_POLL, LEVEL_MAX - 1, 0, 0, CMD_MAX);
        push_beat(OP_POLL, LEVEL_MAX, 0, 0, CMD_MAX);
        push_beat(OP_STEP, 400, 400, 400, CMD_MAX);
        wait_idle();
        write_reg(CFG_LIMIT, 5);
        push_beat(OP_STEP, 400, 400, 400, CMD_MAX);
        push_beat(OP_STEP, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, CMD_MAX);
        push_beat(OP_STEP, 0, 0, 0, CMD_MAX);
        wait_idle();

        // zero span, stall with the drive at center
        write_reg(CFG_NOMINAL, 512);
        write_reg(CFG_STALL_LVL, 512);
        write_reg(CFG_STOP, 1);
        push_beat(OP_STEP, 100, 100, 100, CMD_MAX);
        push_beat(OP_STEP, 100, 100, 100, CMD_MAX);
        wait_idle();

        // long result hold-off while beats keep coming
        idle_odds = 0;
        random_setup();
        @(posedge i_clk);
        hold_request = 1'b1;
        goal = beats_queued + 40;
        while (beats_queued < goal) run_move($urandom_range(1, 12), 1'b1);
        wait_idle();

        // one long measuring move
        idle_odds = 12;
        random_setup();
        write_reg(CFG_STOP, 0);
        write_reg(CFG_LIMIT, MAX_STEPS);
        run_move(300, 1'b1);
        wait_idle();

        phase = 0;
        while (beats_queued < ITEM_GOAL) begin
            if (beats_queued > ITEM_GOAL - 200) begin
                idle_odds = 0;
            end else begin
                case (phase % 3)
                    0: idle_odds = 0;
                    1: idle_odds = 3;
                    default: idle_odds = 12;
                endcase
            end
            random_phase(90);
            phase++;
        end
        wait_idle();

        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
